@@ rtl/core/vector_abs_cosine_or_sine_top_assert.svh @@
// assertion macros shared by the vector measure pipeline
// no dependencies
`ifndef VECTOR_ABS_COSINE_OR_SINE_TOP_ASSERT_SVH
`define VECTOR_ABS_COSINE_OR_SINE_TOP_ASSERT_SVH
`define VACS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define VACS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/vacs_pkg.sv @@
// shared types and constants for the vector measure pipeline
// no dependencies
package vacs_pkg;
  localparam int unsigned CompW   = 32;
  localparam int unsigned MagW    = 32;
  localparam int unsigned SqW     = 66;
  localparam int unsigned NormW   = 33;
  localparam int unsigned DotW    = 66;
  localparam int unsigned DenW    = 66;
  localparam int unsigned NumW    = 82;
  localparam int unsigned MeasW   = 17;
  localparam int unsigned CosBits = 17;
  localparam logic [MeasW-1:0] One = 17'h10000;
endpackage

@@ rtl/core/vacs_isqrt.sv @@
// pipelined integer square root, one result bit per stage
// depends on vacs_pkg
module vacs_isqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [vacs_pkg::SqW-1:0]  op_i,
  output logic [vacs_pkg::NormW-1:0] root_o
);
  localparam int unsigned Steps = vacs_pkg::NormW;
  logic [vacs_pkg::SqW-1:0]   rem_q  [Steps];
  logic [vacs_pkg::NormW-1:0] root_q [Steps];
  logic [vacs_pkg::SqW-1:0]   rem_d  [Steps];
  logic [vacs_pkg::NormW-1:0] root_d [Steps];

  always_comb begin
    for (int s = 0; s < Steps; s++) begin
      logic [vacs_pkg::SqW-1:0]   r_in;
      logic [vacs_pkg::NormW-1:0] q_in;
      logic [vacs_pkg::SqW+1:0]   trial;
      logic [vacs_pkg::SqW+1:0]   sh;
      r_in = (s == 0) ? op_i : rem_q[s-1];
      q_in = (s == 0) ? '0 : root_q[s-1];
      // trial = (4q+1) << 2*bit
      sh    = ({{(vacs_pkg::SqW-vacs_pkg::NormW){1'b0}}, q_in, 2'b01})
              << (2 * (Steps - 1 - s));
      trial = sh;
      if ({2'b00, r_in} >= trial) begin
        rem_d[s]  = r_in - trial[vacs_pkg::SqW-1:0];
        root_d[s] = {q_in[vacs_pkg::NormW-2:0], 1'b1};
      end else begin
        rem_d[s]  = r_in;
        root_d[s] = {q_in[vacs_pkg::NormW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Steps; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
      end
    end
  end

  assign root_o = root_q[Steps-1];
endmodule

@@ rtl/core/vacs_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on vacs_pkg
module vacs_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [vacs_pkg::NumW-1:0] num_i,
  input  logic [vacs_pkg::DenW-1:0] den_i,
  output logic [vacs_pkg::CosBits-1:0] quo_o
);
  localparam int unsigned Steps = vacs_pkg::CosBits;
  localparam int unsigned WW = vacs_pkg::NumW + 1;
  logic [vacs_pkg::NumW-1:0]    num_q [Steps];
  logic [vacs_pkg::DenW-1:0]    den_q [Steps-1];
  logic [vacs_pkg::CosBits-1:0] quo_q [Steps];
  logic [vacs_pkg::NumW-1:0]    num_d [Steps];
  logic [vacs_pkg::CosBits-1:0] quo_d [Steps];

  always_comb begin
    for (int s = 0; s < Steps; s++) begin
      logic [vacs_pkg::NumW-1:0]    n_in;
      logic [vacs_pkg::DenW-1:0]    d_in;
      logic [vacs_pkg::CosBits-1:0] q_in;
      logic [WW-1:0]                t;
      n_in = (s == 0) ? num_i : num_q[s-1];
      d_in = (s == 0) ? den_i : den_q[s-1];
      q_in = (s == 0) ? '0 : quo_q[s-1];
      t = {{(WW-vacs_pkg::DenW){1'b0}}, d_in} << (Steps - 1 - s);
      if ({1'b0, n_in} >= t) begin
        num_d[s] = n_in - t[vacs_pkg::NumW-1:0];
        quo_d[s] = {q_in[vacs_pkg::CosBits-2:0], 1'b1};
      end else begin
        num_d[s] = n_in;
        quo_d[s] = {q_in[vacs_pkg::CosBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Steps; s++) begin
        num_q[s] <= num_d[s];
        quo_q[s] <= quo_d[s];
      end
      for (int s = 0; s < Steps - 1; s++) begin
        den_q[s] <= (s == 0) ? den_i : den_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[Steps-1];
endmodule

@@ rtl/core/vector_abs_cosine_or_sine_top.sv @@
// Vector measure pipeline: one pair of 3D Q16.16 vectors per clock, result
// leaves the pipe after passing through its stages in order
// (products and sums, norm square roots, norm product, quotient bits, clamp and
// square, sine root). All stages advance together; a stall holds the whole
// pipe, so throughput is one word per cycle while the output is not stalled.
// depends on vacs_pkg, vacs_isqrt, vacs_div and the assertion header
`include "vector_abs_cosine_or_sine_top_assert.svh"
module vector_abs_cosine_or_sine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic        want_sine_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] measure_o,
  output logic        zero_vector_o
);
  localparam int unsigned Lat = 91;
  // side band carried alongside the arithmetic
  typedef struct packed {
    logic sine;
    logic zero;
  } side_t;

  logic en;
  logic [Lat-1:0] vld_q;
  side_t side_q [Lat];

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // stage 1: magnitudes and signs
  logic [31:0] ma_q [3];
  logic [31:0] mb_q [3];
  logic [2:0]  ng_q;
  logic signed [31:0] av [3];
  logic signed [31:0] bv [3];
  assign av[0] = a_x_i; assign av[1] = a_y_i; assign av[2] = a_z_i;
  assign bv[0] = b_x_i; assign bv[1] = b_y_i; assign bv[2] = b_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ma_q[i] <= av[i][31] ? 32'(-av[i]) : av[i];
        mb_q[i] <= bv[i][31] ? 32'(-bv[i]) : bv[i];
        ng_q[i] <= av[i][31] ^ bv[i][31];
      end
    end
  end

  // stage 2: products
  logic [63:0] sqa_q [3];
  logic [63:0] sqb_q [3];
  logic [63:0] pr_q  [3];
  logic [2:0]  ng2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqa_q[i] <= ma_q[i] * ma_q[i];
        sqb_q[i] <= mb_q[i] * mb_q[i];
        pr_q[i]  <= ma_q[i] * mb_q[i];
      end
      ng2_q <= ng_q;
    end
  end

  // stage 3: sums
  logic [65:0] sa_q, sb_q, pos_q, neg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q  <= 66'(sqa_q[0]) + 66'(sqa_q[1]) + 66'(sqa_q[2]);
      sb_q  <= 66'(sqb_q[0]) + 66'(sqb_q[1]) + 66'(sqb_q[2]);
      pos_q <= (ng2_q[0] ? 66'd0 : 66'(pr_q[0])) + (ng2_q[1] ? 66'd0 : 66'(pr_q[1]))
             + (ng2_q[2] ? 66'd0 : 66'(pr_q[2]));
      neg_q <= (ng2_q[0] ? 66'(pr_q[0]) : 66'd0) + (ng2_q[1] ? 66'(pr_q[1]) : 66'd0)
             + (ng2_q[2] ? 66'(pr_q[2]) : 66'd0);
    end
  end

  // stage 4: dot magnitude
  logic [65:0] d_q, sa4_q, sb4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q   <= (pos_q >= neg_q) ? pos_q - neg_q : neg_q - pos_q;
      sa4_q <= sa_q;
      sb4_q <= sb_q;
    end
  end

  // norms
  logic [32:0] na, nb;
  vacs_isqrt u_sqa (.clk_i, .en_i(en), .op_i(sa4_q), .root_o(na));
  vacs_isqrt u_sqb (.clk_i, .en_i(en), .op_i(sb4_q), .root_o(nb));

  // dot delayed alongside the square roots
  logic [65:0] dd_q [33];
  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_q[0] <= d_q;
      for (int i = 1; i < 33; i++) dd_q[i] <= dd_q[i-1];
    end
  end

  // norm product split over two stages of 33x17 / 33x16 partials
  logic [49:0] plo_q;
  logic [48:0] phi_q;
  logic [65:0] dn_q, dn2_q, den_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_q <= 50'(na) * 50'(nb[15:0]);
      phi_q <= 49'(na) * 49'(nb[32:16]);
      dn_q  <= dd_q[32];
      den_q <= 66'(plo_q) + (66'(phi_q) << 16);
      dn2_q <= dn_q;
    end
  end

  logic [16:0] quo;
  vacs_div u_div (.clk_i, .en_i(en), .num_i({dn2_q, 16'd0}), .den_i(den_q),
                  .quo_o(quo));

  // quotient above 2^17 impossible to show; no overflow flag from a den check:
  // quotient bits cover 0..2^17-1, a larger quotient saturates to all ones and is then clamped
  logic [16:0] c_q;
  logic [33:0] csq_q;
  logic [16:0] c2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q   <= (quo > vacs_pkg::One) ? vacs_pkg::One : quo;
      csq_q <= 34'(c_q) * 34'(c_q);
      c2_q  <= c_q;
    end
  end

  logic [32:0] sroot;
  vacs_isqrt u_sin (.clk_i, .en_i(en), .op_i(66'(34'h100000000 - csq_q)),
                    .root_o(sroot));
  logic [16:0] cd_q [33];
  always_ff @(posedge clk_i) begin
    if (en) begin
      cd_q[0] <= c2_q;
      for (int i = 1; i < 33; i++) cd_q[i] <= cd_q[i-1];
    end
  end

  // side band: zero detect at stage 4 timing
  side_t side_in;
  assign side_in.sine = want_sine_i;
  assign side_in.zero = 1'b0;
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < Lat; i++) begin
        if (i == 4) begin
          side_q[i] <= '{sine: side_q[i-1].sine, zero: (sa4_q == '0) || (sb4_q == '0)};
        end else begin
          side_q[i] <= side_q[i-1];
        end
      end
    end
  end

  always_comb begin
    out_valid_o   = vld_q[Lat-1];
    zero_vector_o = side_q[Lat-1].zero;
    if (side_q[Lat-1].zero) measure_o = '0;
    else if (side_q[Lat-1].sine) measure_o = sroot[16:0];
    else measure_o = cd_q[32];
  end

  `VACS_ASSERT_IMPL(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o, "pipe moved under stall")
  `VACS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(measure_o), "output changed under stall")
  `VACS_ASSERT_IMPL(a_zero_meas, clk_i, rst_ni, out_valid_o && zero_vector_o, measure_o == '0, "zero vector gave nonzero")
  `VACS_ASSERT_IMPL(a_range, clk_i, rst_ni, out_valid_o, measure_o <= vacs_pkg::One, "measure above one")
endmodule

@@ test/tb.sv @@
// testbench for vector_abs_cosine_or_sine_top: abs cosine / sine of two 3d vectors
// self-checking against an in-bench predictor; depends on the rtl top only
`timescale 1ns / 1ps
module tb;
  localparam int unsigned LATENCY = 91;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic               sine;
  } pair_t;

  typedef struct packed {
    logic [16:0] meas;
    logic        zero;
  } measure_t;

  typedef struct {
    pair_t    p;
    logic     known;
    measure_t m;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic signed [31:0] b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic want_sine_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [16:0] measure_o;
  logic zero_vector_o;

  measure_t expected_q[$];
  int errors = 0;
  int idle_in = 0, idle_out = 0;
  bit hold_out = 1'b0;
  longint unsigned cycles = 0;

  vector_abs_cosine_or_sine_top uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= 64'd1 << b;
    return r;
  endfunction

  function automatic logic [31:0] mag(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic measure_t angle_measure(pair_t p);
    logic [63:0] sa, sb, pos, negs, d, na, nb, c;
    logic [31:0] ma[3], mb[3];
    logic sa_n[3], sb_n[3];
    logic [127:0] num, den;
    measure_t r;
    ma = '{mag(p.ax), mag(p.ay), mag(p.az)};
    mb = '{mag(p.bx), mag(p.by), mag(p.bz)};
    sa_n = '{p.ax[31], p.ay[31], p.az[31]};
    sb_n = '{p.bx[31], p.by[31], p.bz[31]};
    sa = 0; sb = 0; pos = 0; negs = 0;
    for (int i = 0; i < 3; i++) begin
      sa += 64'(ma[i]) * ma[i];
      sb += 64'(mb[i]) * mb[i];
      if (sa_n[i] != sb_n[i]) negs += 64'(ma[i]) * mb[i];
      else pos += 64'(ma[i]) * mb[i];
    end
    if (sa == 0 || sb == 0) return '{meas: '0, zero: 1'b1};
    d = pos >= negs ? pos - negs : negs - pos;
    na = root64(sa);
    nb = root64(sb);
    num = 128'(d) << 16;
    den = 128'(na) * nb;
    c = 64'(num / den);
    if (c > 65536) c = 65536;
    if (p.sine) c = root64((64'd1 << 32) - c * c);
    r.meas = c[16:0];
    r.zero = 1'b0;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      1: return 32'($signed($urandom_range(0, 16)) - 8);
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(pair_t p);
    while (idle_in > 0 && $urandom_range(0, 99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, want_sine_i} <= p;
    expected_q.push_back(angle_measure(p));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() > 0) @(posedge clk_i);
  endtask

  // receiver side: random stalls, or a long hold-off
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (hold_out) out_stall_i <= 1'b1;
    else out_stall_i <= idle_out > 0 && $urandom_range(0, 99) < idle_out;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected word", 32'(measure_o), 32'd0);
      end else begin
        measure_t e;
        e = expected_q.pop_front();
        if (measure_o !== e.meas) report("measure", 32'(measure_o), 32'(e.meas));
        if (zero_vector_o !== e.zero)
          report("zero_vector", 32'(zero_vector_o), 32'(e.zero));
      end
    end
  end

  localparam logic signed [31:0] MN = 32'sh8000_0000, MX = 32'sh7fff_ffff;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  row_t directed[] = '{
    '{'{0, 0, 0, ONE, 0, 0, 0}, 1, '{0, 1}},
    '{'{ONE, 0, 0, 0, 0, 0, 1}, 1, '{0, 1}},
    '{'{0, 0, 0, 0, 0, 0, 1}, 1, '{0, 1}},
    '{'{ONE, 0, 0, ONE, 0, 0, 0}, 1, '{17'h10000, 0}},
    '{'{ONE, 0, 0, ONE, 0, 0, 1}, 1, '{0, 0}},
    '{'{ONE, 0, 0, 0, ONE, 0, 0}, 1, '{0, 0}},
    '{'{ONE, 0, 0, 0, ONE, 0, 1}, 1, '{17'h10000, 0}},
    '{'{ONE, 0, 0, -ONE, 0, 0, 0}, 1, '{17'h10000, 0}},
    '{'{MN, MN, MN, MN, MN, MN, 0}, 0, '{0, 0}},
    '{'{MN, MN, MN, MX, MX, MX, 1}, 0, '{0, 0}},
    '{'{MX, MX, MX, MX, MX, MX, 0}, 0, '{0, 0}},
    '{'{MX, MN, MX, MN, MX, MN, 1}, 0, '{0, 0}},
    '{'{1, 1, 1, 1, 1, 1, 0}, 0, '{0, 0}},
    '{'{1, 1, 0, 1, 0, 0, 0}, 0, '{0, 0}},
    '{'{-1, 0, 0, 0, 0, -1, 1}, 0, '{0, 0}},
    '{'{3, 4, 0, 4, 3, 0, 0}, 0, '{0, 0}},
    '{'{MN, 0, 0, 0, 0, 1, 0}, 0, '{0, 0}},
    '{'{-1, -1, -1, -1, -1, -1, 1}, 0, '{0, 0}}
  };

  task automatic random_items(int n);
    pair_t p;
    repeat (n) begin
      p.ax = rand_comp(); p.ay = rand_comp(); p.az = rand_comp();
      p.bx = rand_comp(); p.by = rand_comp(); p.bz = rand_comp();
      p.sine = $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) {p.bx, p.by, p.bz} = {p.ax, p.ay, p.az};
      send(p);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      if (directed[i].known && angle_measure(directed[i].p) !== directed[i].m)
        report("predictor row", 32'(i), 32'd0);
      send(directed[i].p);
    end
    idle_in = 15; idle_out = 83;
    random_items(200);
    drain();
    idle_in = 83; idle_out = 15;
    random_items(150);
    // long receiver hold-off so the pipe fills and stalls its input
    idle_in = 0; idle_out = 0;
    fork
      begin
        hold_out = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_out = 1'b0;
      end
      random_items(120);
    join
    drain();
    random_items(180);
    drain();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/vacs_pkg.sv
rtl/core/vacs_isqrt.sv
rtl/core/vacs_div.sv
rtl/core/vector_abs_cosine_or_sine_top.sv
test/tb.sv
